### rtl/descriptor_two_nn_matcher_assert.svh
// Assertion macros used by the matcher top module.
`ifndef DESCRIPTOR_TWO_NN_MATCHER_ASSERT_SVH
`define DESCRIPTOR_TWO_NN_MATCHER_ASSERT_SVH

`ifndef SYNTH

`define DTNM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtnm assertion failed");

`define DTNM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtnm assertion failed");

`else

`define DTNM_ASSERT(lbl, ante, cons)

`define DTNM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/dtnm_pkg.sv
`default_nettype none

package dtnm_pkg;

  localparam int Dimension = 128;
  localparam int Lanes     = 8;
  localparam int Chunks    = Dimension / Lanes;
  localparam int ChunkBits = $clog2(Chunks);

  localparam int ElemBits  = 8;
  localparam int ChunkW    = 64;
  localparam int PosBits   = 4;
  localparam int IdxBits   = 16;
  localparam int DistBits  = 23;
  localparam int RatioBits = 9;
  localparam int ProdBits  = 2 * ElemBits;
  localparam int SumBits   = ProdBits + $clog2(Lanes);
  localparam int RhsBits   = RatioBits + DistBits;
  localparam int CfgData   = 32;

  localparam logic [DistBits-1:0]  NormOneReset = 23'd262144;
  localparam logic [RatioBits-1:0] RatioReset   = 9'd164;
  localparam logic [DistBits-1:0]  AccMax       = {DistBits{1'b1}};

  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_COMPARE = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_NORM_ONE      = 1'b0,
    REG_RATIO_SQUARED = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ACC,
    ST_DIST,
    ST_RANK,
    ST_RATIO,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [ChunkW-1:0]   chunk;
    logic [PosBits-1:0]  chunk_position;
    logic [IdxBits-1:0]  reference_index;
    logic                last_reference;
  } in_beat_t;

  typedef struct packed {
    logic [IdxBits-1:0]  best_index;
    logic [IdxBits-1:0]  second_index;
    logic [DistBits-1:0] best_distance;
    logic [DistBits-1:0] second_distance;
    logic [1:0]          neighbours_found;
    logic                ratio_pass;
  } out_beat_t;

  typedef struct packed {
    logic sum_en;
    logic acc_en;
    logic dist_en;
  } merge_ctrl_t;

  typedef struct packed {
    logic ins_en;
    logic mul_en;
    logic emit;
  } rank_ctrl_t;

endpackage

`default_nettype wire

### rtl/descriptor_two_nn_matcher.sv
// Two-nearest-neighbor descriptor matcher with a ratio test.
// Input channel: in_valid_i/in_stall_o with one in_data_i beat per accepted item.
// A load beat stores one query chunk without stalling the input. A compare
// beat multiplies its chunk with the stored query chunk in eight lanes, sums
// the products and adds them to the dot-product accumulator (MUL, SUM, ACC).
// The final chunk of a reference also computes its distance and updates the
// two nearest neighbors (DIST, RANK). On the final chunk of the last reference
// the ratio product is formed (RATIO) and the EMIT step registers the result
// beat, which then appears on out_valid_o. The block works on one compare
// beat at a time; the sequencer steps one chunk through the lane multipliers,
// the adder tree and the ranking unit. in_stall_o is high while a compare
// beat is in flight. A finished result sits in the output register until
// out_stall_i is low; a further compare beat may enter meanwhile, and only a
// new result waits. Configuration uses cfg_valid_i/cfg_ready_o; the user must
// write it only while idle, as the block does not enforce this. Reset clears
// the accumulator, the neighbor count and the output valid, and restores the
// register defaults. Query chunks must be loaded before use.

`default_nettype none

`include "descriptor_two_nn_matcher_assert.svh"

module descriptor_two_nn_matcher (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire dtnm_pkg::in_beat_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output dtnm_pkg::out_beat_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [0:0]                        cfg_index_i,
  input  wire logic [dtnm_pkg::CfgData-1:0]      cfg_data_i
);

  dtnm_pkg::state_e      state_d, state_q;
  dtnm_pkg::in_beat_t    item_q;
  dtnm_pkg::merge_ctrl_t merge_ctrl;
  dtnm_pkg::rank_ctrl_t  rank_ctrl;
  dtnm_pkg::out_beat_t   result;
  dtnm_pkg::out_beat_t   out_data_q;

  logic [dtnm_pkg::ChunkW-1:0]    mem_q [dtnm_pkg::Chunks];
  logic [dtnm_pkg::ChunkW-1:0]    rd_q;
  logic [dtnm_pkg::Lanes-1:0][dtnm_pkg::ProdBits-1:0] prod;
  logic [dtnm_pkg::DistBits-1:0]  norm_q, ref_dist;
  logic [dtnm_pkg::RatioBits-1:0] ratio_q;
  logic                           in_acc, pos_ok, is_final, out_free, out_valid_q;
  logic                           lane_en;

  assign in_stall_o  = (state_q != dtnm_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pos_ok      = (32'(in_data_i.chunk_position) < dtnm_pkg::Chunks);
  assign is_final    = (item_q.chunk_position == dtnm_pkg::PosBits'(dtnm_pkg::Chunks - 1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_acc && pos_ok && in_data_i.command == dtnm_pkg::CMD_LOAD) begin
      mem_q[in_data_i.chunk_position[dtnm_pkg::ChunkBits-1:0]] <= in_data_i.chunk;
    end
    if (in_acc) begin
      rd_q   <= mem_q[in_data_i.chunk_position[dtnm_pkg::ChunkBits-1:0]];
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q  <= dtnm_pkg::NormOneReset;
      ratio_q <= dtnm_pkg::RatioReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dtnm_pkg::cfg_reg_e'(cfg_index_i))
        dtnm_pkg::REG_NORM_ONE:      norm_q  <= cfg_data_i[dtnm_pkg::DistBits-1:0];
        dtnm_pkg::REG_RATIO_SQUARED: ratio_q <= cfg_data_i[dtnm_pkg::RatioBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtnm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    lane_en    = 1'b0;
    merge_ctrl = '0;
    rank_ctrl  = '0;
    case (state_q)
      dtnm_pkg::ST_IDLE: begin
        if (in_acc && pos_ok && in_data_i.command == dtnm_pkg::CMD_COMPARE) begin
          state_d = dtnm_pkg::ST_MUL;
        end
      end
      dtnm_pkg::ST_MUL: begin
        lane_en = 1'b1;
        state_d = dtnm_pkg::ST_SUM;
      end
      dtnm_pkg::ST_SUM: begin
        merge_ctrl.sum_en = 1'b1;
        state_d           = dtnm_pkg::ST_ACC;
      end
      dtnm_pkg::ST_ACC: begin
        merge_ctrl.acc_en = 1'b1;
        state_d           = is_final ? dtnm_pkg::ST_DIST : dtnm_pkg::ST_IDLE;
      end
      dtnm_pkg::ST_DIST: begin
        merge_ctrl.dist_en = 1'b1;
        state_d            = dtnm_pkg::ST_RANK;
      end
      dtnm_pkg::ST_RANK: begin
        rank_ctrl.ins_en = 1'b1;
        state_d = item_q.last_reference ? dtnm_pkg::ST_RATIO : dtnm_pkg::ST_IDLE;
      end
      dtnm_pkg::ST_RATIO: begin
        rank_ctrl.mul_en = 1'b1;
        state_d          = dtnm_pkg::ST_EMIT;
      end
      dtnm_pkg::ST_EMIT: begin
        if (out_free) begin
          rank_ctrl.emit = 1'b1;
          state_d        = dtnm_pkg::ST_IDLE;
        end
      end
      default: state_d = dtnm_pkg::ST_IDLE;
    endcase
  end

  for (genvar l = 0; l < dtnm_pkg::Lanes; l++) begin : g_lane
    dtnm_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .query_i (rd_q[l*dtnm_pkg::ElemBits +: dtnm_pkg::ElemBits]),
      .ref_i   (item_q.chunk[l*dtnm_pkg::ElemBits +: dtnm_pkg::ElemBits]),
      .prod_o  (prod[l])
    );
  end

  dtnm_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (merge_ctrl),
    .prod_i     (prod),
    .norm_one_i (norm_q),
    .dist_o     (ref_dist)
  );

  dtnm_rank u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rank_ctrl),
    .dist_i   (ref_dist),
    .idx_i    (item_q.reference_index),
    .ratio_i  (ratio_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rank_ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rank_ctrl.emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A compare beat at an in-range position always starts the lane multiply.
  `DTNM_ASSERT_NEXT(a_compare_starts, in_acc && pos_ok && in_data_i.command == dtnm_pkg::CMD_COMPARE, state_q == dtnm_pkg::ST_MUL)
  // A new result only appears after the emit step.
  `DTNM_ASSERT(a_rise_after_emit, $rose(out_valid_o), $past(state_q) == dtnm_pkg::ST_EMIT)
  // The ratio test only passes with two neighbors held.
  `DTNM_ASSERT(a_pass_needs_two, out_valid_o && out_data_o.ratio_pass, out_data_o.neighbours_found == 2'd2)
  // The neighbor count never exceeds two.
  `DTNM_ASSERT(a_found_range, out_valid_o, out_data_o.neighbours_found != 2'd3)

endmodule

`default_nettype wire

### rtl/dtnm_lane.sv
`default_nettype none

module dtnm_lane (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [dtnm_pkg::ElemBits-1:0]      query_i,
  input  wire logic [dtnm_pkg::ElemBits-1:0]      ref_i,
  output logic      [dtnm_pkg::ProdBits-1:0]      prod_o
);

  logic [dtnm_pkg::ProdBits-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= query_i * ref_i;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/dtnm_merge.sv
`default_nettype none

module dtnm_merge (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire dtnm_pkg::merge_ctrl_t                           ctrl_i,
  input  wire logic [dtnm_pkg::Lanes-1:0][dtnm_pkg::ProdBits-1:0] prod_i,
  input  wire logic [dtnm_pkg::DistBits-1:0]                   norm_one_i,
  output logic      [dtnm_pkg::DistBits-1:0]                   dist_o
);

  logic [dtnm_pkg::SumBits-1:0]  sum_d, sum_q;
  logic [dtnm_pkg::DistBits-1:0] acc_d, acc_q;
  logic [dtnm_pkg::DistBits:0]   acc_wide;
  logic [dtnm_pkg::DistBits-1:0] dist_d, dist_q;

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < dtnm_pkg::Lanes; l++) begin
      sum_d = sum_d + dtnm_pkg::SumBits'(prod_i[l]);
    end
  end

  always_comb begin
    acc_wide = {1'b0, acc_q} + (dtnm_pkg::DistBits + 1)'(sum_q);
    acc_d    = acc_wide[dtnm_pkg::DistBits] ? dtnm_pkg::AccMax
                                            : acc_wide[dtnm_pkg::DistBits-1:0];
    dist_d   = (norm_one_i > acc_q) ? (norm_one_i - acc_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
    end
    if (ctrl_i.dist_en) begin
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.dist_en) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

### rtl/dtnm_rank.sv
`default_nettype none

module dtnm_rank (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dtnm_pkg::rank_ctrl_t              ctrl_i,
  input  wire logic [dtnm_pkg::DistBits-1:0]     dist_i,
  input  wire logic [dtnm_pkg::IdxBits-1:0]      idx_i,
  input  wire logic [dtnm_pkg::RatioBits-1:0]    ratio_i,
  output dtnm_pkg::out_beat_t                    result_o
);

  logic [dtnm_pkg::DistBits-1:0] near_d, near_q, sec_d, sec_q;
  logic [dtnm_pkg::IdxBits-1:0]  nidx_d, nidx_q, sidx_d, sidx_q;
  logic [1:0]                    found_d, found_q;
  logic [dtnm_pkg::RhsBits-1:0]  rhs_q;
  logic [dtnm_pkg::RhsBits-1:0]  lhs;
  logic                          have1, have2;

  always_comb begin
    near_d  = near_q;
    sec_d   = sec_q;
    nidx_d  = nidx_q;
    sidx_d  = sidx_q;
    found_d = found_q;
    if (ctrl_i.emit) begin
      found_d = '0;
    end else if (ctrl_i.ins_en) begin
      if (found_q == 2'd0) begin
        near_d  = dist_i;
        nidx_d  = idx_i;
        found_d = 2'd1;
      end else if (dist_i < near_q) begin
        sec_d  = near_q;
        sidx_d = nidx_q;
        near_d = dist_i;
        nidx_d = idx_i;
        if (found_q < 2'd2) begin
          found_d = found_q + 2'd1;
        end
      end else if (found_q == 2'd1 || dist_i < sec_q) begin
        sec_d   = dist_i;
        sidx_d  = idx_i;
        found_d = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q  <= '0;
      sec_q   <= '0;
      nidx_q  <= '0;
      sidx_q  <= '0;
      found_q <= '0;
    end else begin
      near_q  <= near_d;
      sec_q   <= sec_d;
      nidx_q  <= nidx_d;
      sidx_q  <= sidx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      rhs_q <= ratio_i * sec_q;
    end
  end

  always_comb begin
    have1 = (found_q != 2'd0);
    have2 = (found_q == 2'd2);
    lhs   = {1'b0, near_q, 8'd0};
    result_o.best_index       = have1 ? nidx_q : '0;
    result_o.second_index     = have2 ? sidx_q : '0;
    result_o.best_distance    = have1 ? near_q : '0;
    result_o.second_distance  = have2 ? sec_q : '0;
    result_o.neighbours_found = found_q;
    result_o.ratio_pass       = have2 && (lhs < rhs_q);
  end

endmodule

`default_nettype wire
